/* sv/slt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch lap timer package
// Shared constants, button codes, segment table and the per-cell control
// bundle used by the digit chain.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Digit chain: hundredths ones, hundredths tens, seconds ones,
  // seconds tens, minutes ones, minutes tens
  localparam int NUM_DIGITS = 6;
  localparam logic [3:0] DIGIT_MAX [NUM_DIGITS] = '{
    4'd9, 4'd9, 4'd9, 4'd5, 4'd9, 4'd5
  };

  // Button bank codes; only these exact values act
  localparam logic [3:0] BTN_RUN   = 4'd1;
  localparam logic [3:0] BTN_PAUSE = 4'd2;
  localparam logic [3:0] BTN_LAP   = 4'd4;
  localparam logic [3:0] BTN_CLEAR = 4'd8;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;

  // Control bundle broadcast to every digit cell
  typedef struct packed {
    logic step;      // running tick on an accepted beat
    logic clear;     // clear button on an accepted beat
    logic capture;   // lap button on an accepted beat
    logic view_lap;  // view selection latched by the previous beat
  } ctrl_t;

  // Seven-segment code, active high, bit 0 = segment a
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h67;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

/* sv/slt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch digit cell
// One decimal digit of the running count, its last shown value, its lap copy
// and its display byte. Takes a carry from the lower digit and hands one on.
// ----------------------------------------------------------------------------
module slt_cell
  import slt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ctrl_t      ctrl,
  input  logic [3:0] digit_max,
  input  logic       carry_in,
  output logic       carry_out,
  output logic [7:0] seg
);

  logic [3:0] cnt;
  logic [3:0] shown;
  logic [3:0] lap;
  logic [3:0] cnt_inc;
  logic [3:0] shown_next;
  logic       wrap;
  logic       adv;

  // Advance when the lower digits roll over on a running tick
  assign wrap      = (cnt == digit_max);
  assign adv       = ctrl.step & carry_in;
  assign carry_out = carry_in & wrap;
  assign cnt_inc   = adv ? (wrap ? 4'd0 : cnt + 4'd1) : cnt;
  assign shown_next = ctrl.step ? cnt_inc : shown;

  // Hold count, shown time, lap and display byte
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= 4'd0;
      shown <= 4'd0;
      lap   <= 4'd0;
      seg   <= 8'h00;
    end else begin
      shown <= shown_next;
      if (ctrl.clear) begin
        cnt <= 4'd0;
        lap <= 4'd0;
        seg <= seg_code(4'd0);
      end else begin
        cnt <= cnt_inc;
        if (ctrl.capture) begin
          lap <= shown_next;
        end
        if (ctrl.step) begin
          seg <= ctrl.view_lap ? seg_code(lap) : seg_code(cnt_inc);
        end
      end
    end
  end

endmodule

/* sv/stopwatch_lap_timer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch lap timer top level
// Takes one beat per clock while no result is stalled, and returns one beat
// per input beat: the six segment bytes after the beat and the pause state.
// The result is registered and appears in the cycle after the input beat is
// taken; the carry ripples through the chain of six digit cells. A new beat
// is taken while the previous result is being taken on the output side.
// ----------------------------------------------------------------------------
module stopwatch_lap_timer_top
  import slt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [0] tick, [4:1] buttons, [5] lap_switch, [7:6] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] digits_low, [47:32] digits_high, [48] is_paused, [55:49] zero
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic       s_acc;
  logic       tick;
  logic [3:0] buttons;
  logic       lap_switch;
  logic       paused;
  logic       view_lap;
  ctrl_t      ctrl;
  logic       carry [NUM_DIGITS+1];
  logic [7:0] seg   [NUM_DIGITS];

  assign tick       = s_tdata[0];
  assign buttons    = s_tdata[4:1];
  assign lap_switch = s_tdata[5];

  // Take a beat when the output slot is free or being drained
  assign s_tready = ~m_tvalid | m_tready;
  assign s_acc    = s_tvalid & s_tready;

  // Broadcast control to the digit chain
  assign ctrl.step     = s_acc & tick & ~paused;
  assign ctrl.clear    = s_acc & (buttons == BTN_CLEAR);
  assign ctrl.capture  = s_acc & (buttons == BTN_LAP);
  assign ctrl.view_lap = view_lap;

  assign carry[0] = 1'b1;

  // Chain of digit cells, lowest digit first
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    slt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .digit_max (DIGIT_MAX[i]),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .seg       (seg[i])
    );
  end

  // Latch view selection and pause state, track the output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      paused   <= 1'b0;
      view_lap <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_acc) begin
        view_lap <= lap_switch;
        if (buttons == BTN_RUN) begin
          paused <= 1'b0;
        end else if (buttons == BTN_PAUSE) begin
          paused <= 1'b1;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Present the display state as the result beat
  assign m_tdata = {7'd0, paused, seg[5], seg[4], seg[3], seg[2], seg[1], seg[0]};

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result stalled");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (buttons == BTN_CLEAR)) |=>
      (m_tdata[47:0] == {6{seg_code(4'd0)}}))
    else $error("clear did not show zeros");

  a_pause_flag: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (buttons == BTN_PAUSE)) |=> m_tdata[48])
    else $error("pause not reported");

  a_paused_holds: assert property (@(posedge clk) disable iff (rst)
    (s_acc && paused && (buttons != BTN_CLEAR)) |=> $stable(m_tdata[47:0]))
    else $error("display moved while paused");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch lap timer testbench
// Drives tick, button and lap-switch samples into the stream input and checks
// every output beat against a cycle-free model of the stopwatch: a short
// table of directed samples, then random run/pause/lap/clear traffic with
// random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
  import slt_pkg::*;

  localparam int unsigned HOUR_CENTIS = 360000;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [3:0]  BTN_NONE    = 4'd0;

  // Segment font, active high, bit 0 = segment a
  localparam logic [7:0] SEG_FONT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
  };

  typedef struct packed {
    logic [31:0] low;
    logic [15:0] high;
    logic        paused;
  } readout_t;

  // One directed sample; typed rows carry the readout that must come back
  typedef struct packed {
    logic        tick;
    logic [3:0]  btn;
    logic        sw;
    logic        typed;
    logic [47:0] segs;
    logic        paused;
  } sample_row_t;

  localparam int NUM_ROWS = 24;
  localparam sample_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{1'b0, BTN_NONE,  1'b0, 1'b1, 48'h0000_0000_0000, 1'b0},
    '{1'b1, BTN_NONE,  1'b0, 1'b1, 48'h3F3F_3F3F_3F06, 1'b0},
    '{1'b1, BTN_PAUSE, 1'b0, 1'b1, 48'h3F3F_3F3F_3F5B, 1'b1},
    '{1'b1, BTN_NONE,  1'b0, 1'b1, 48'h3F3F_3F3F_3F5B, 1'b1},
    '{1'b0, BTN_RUN,   1'b0, 1'b0, 48'h0,              1'b0},
    '{1'b1, BTN_LAP,   1'b1, 1'b0, 48'h0,              1'b0},
    '{1'b1, BTN_NONE,  1'b1, 1'b0, 48'h0,              1'b0},
    '{1'b1, BTN_CLEAR, 1'b0, 1'b1, 48'h3F3F_3F3F_3F3F, 1'b0},
    '{1'b0, BTN_LAP,   1'b1, 1'b0, 48'h0,              1'b0},
    '{1'b1, BTN_NONE,  1'b1, 1'b0, 48'h0,              1'b0},
    '{1'b1, BTN_PAUSE, 1'b0, 1'b0, 48'h0,              1'b0},
    '{1'b0, BTN_CLEAR, 1'b0, 1'b1, 48'h3F3F_3F3F_3F3F, 1'b1},
    '{1'b1, 4'd3,      1'b0, 1'b0, 48'h0,              1'b0},
    '{1'b1, 4'd15,     1'b1, 1'b0, 48'h0,              1'b0},
    '{1'b0, BTN_RUN,   1'b0, 1'b0, 48'h0,              1'b0},
    '{1'b1, 4'd5,      1'b1, 1'b0, 48'h0,              1'b0},
    '{1'b1, 4'd6,      1'b0, 1'b0, 48'h0,              1'b0},
    '{1'b1, 4'd7,      1'b0, 1'b0, 48'h0,              1'b0},
    '{1'b1, 4'd9,      1'b1, 1'b0, 48'h0,              1'b0},
    '{1'b1, 4'd10,     1'b0, 1'b0, 48'h0,              1'b0},
    '{1'b1, 4'd11,     1'b0, 1'b0, 48'h0,              1'b0},
    '{1'b1, 4'd12,     1'b1, 1'b0, 48'h0,              1'b0},
    '{1'b1, 4'd13,     1'b0, 1'b0, 48'h0,              1'b0},
    '{1'b1, 4'd14,     1'b0, 1'b0, 48'h0,              1'b0}
  };

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Stopwatch model state
  int unsigned centi_count = 0;
  logic        run_paused  = 1'b0;
  logic        view_lap    = 1'b0;
  int unsigned live_min = 0, live_sec = 0, live_cen = 0;
  int unsigned lap_min  = 0, lap_sec  = 0, lap_cen  = 0;
  logic [47:0] face_segs = '0;

  readout_t    pending_readouts [$];
  int unsigned fault_count  = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold      = 0;

  stopwatch_lap_timer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] pair_segs(input int unsigned v);
    return {SEG_FONT[(v / 10) % 10], SEG_FONT[v % 10]};
  endfunction

  function automatic logic [47:0] time_segs(input int unsigned m, input int unsigned s,
                                            input int unsigned c);
    return {pair_segs(m), pair_segs(s), pair_segs(c)};
  endfunction

  // Advance the stopwatch by one sample and return the readout it leaves
  function automatic readout_t step_stopwatch(input logic tick, input logic [3:0] btn,
                                              input logic sw);
    readout_t    r;
    int unsigned secs;
    if (!run_paused && tick) begin
      centi_count = (centi_count + 1) & 32'h7FFFF;
      if (centi_count >= HOUR_CENTIS) centi_count = 0;
      secs     = centi_count / 100;
      live_min = (secs / 60) % 60;
      live_sec = secs % 60;
      live_cen = centi_count % 100;
      face_segs = view_lap ? time_segs(lap_min, lap_sec, lap_cen)
                           : time_segs(live_min, live_sec, live_cen);
    end
    view_lap = sw;
    case (btn)
      BTN_RUN:   run_paused = 1'b0;
      BTN_PAUSE: run_paused = 1'b1;
      BTN_LAP: begin
        lap_min = live_min;
        lap_sec = live_sec;
        lap_cen = live_cen;
      end
      BTN_CLEAR: begin
        lap_min     = 0;
        lap_sec     = 0;
        lap_cen     = 0;
        centi_count = 0;
        face_segs   = time_segs(0, 0, 0);
      end
      default: ;
    endcase
    r.low    = face_segs[31:0];
    r.high   = face_segs[47:32];
    r.paused = run_paused;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Present one sample after an optional gap and hold it until taken
  task automatic offer_sample(input logic tick, input logic [3:0] btn, input logic sw);
    int unsigned gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {2'b00, sw, btn, tick};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_checked(input logic tick, input logic [3:0] btn, input logic sw);
    offer_sample(tick, btn, sw);
    pending_readouts.push_back(step_stopwatch(tick, btn, sw));
  endtask

  // Drop valid and hold until every readout has come back
  task automatic drain_readouts();
    s_tvalid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
  endtask

  // Compare one output beat with the oldest expected readout
  task automatic check_readout(input logic [OUT_DATA_W-1:0] beat);
    readout_t want;
    if (pending_readouts.size() == 0) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("unexpected beat: low %h high %h paused %b",
                 beat[31:0], beat[47:32], beat[48]);
    end else begin
      want = pending_readouts.pop_front();
      if (beat[31:0] !== want.low || beat[47:32] !== want.high ||
          beat[48] !== want.paused) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("mismatch: expected low %h high %h paused %b, got low %h high %h paused %b",
                   want.low, want.high, want.paused, beat[31:0], beat[47:32], beat[48]);
      end
    end
  endtask

  // Output side: check taken beats, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_readout(m_tdata);
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        rx_hold = pick_gap(100) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run after too long with no beat on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    readout_t    got;
    sample_row_t row;
    logic        sw;
    logic        tick;
    logic [3:0]  btn;
    int unsigned r;
    int unsigned tx_pct [4];
    int unsigned rx_pct [4];
    tx_pct = '{30, 0, 60, 10};
    rx_pct = '{30, 0, 10, 60};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      offer_sample(row.tick, row.btn, row.sw);
      got = step_stopwatch(row.tick, row.btn, row.sw);
      if (row.typed) begin
        got.low    = row.segs[31:0];
        got.high   = row.segs[47:32];
        got.paused = row.paused;
      end
      pending_readouts.push_back(got);
    end

    // Random traffic in phases of differing gap and stall pressure
    sw = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      for (int i = 0; i < 400; i++) begin
        if ($urandom_range(0, 99) < 5) sw = ~sw;
        tick = ($urandom_range(0, 99) < 80);
        r = $urandom_range(0, 99);
        if (r < 78) begin
          btn = BTN_NONE;
        end else if (r < 94) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: btn = BTN_RUN;
            4, 5:       btn = BTN_PAUSE;
            6, 7, 8:    btn = BTN_LAP;
            default:    btn = BTN_CLEAR;
          endcase
        end else begin
          btn = 4'($urandom_range(0, 15));
        end
        send_checked(tick, btn, sw);
      end
      if (ph == 0) drain_readouts();
    end

    // Let the last readouts arrive, then settle
    drain_readouts();
    repeat (4) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
